// ===== hw/rtl/rsp_pkg.sv =====
// shared constants and types for the range sum pair counter
`timescale 1ns / 1ps

package rsp_pkg;

  localparam int MaxItems   = 1024;
  localparam int StoreDepth = MaxItems + 1;
  localparam int CntW       = $clog2(StoreDepth + 1);
  localparam int ValW       = 32;
  localparam int PrefW      = ValW + $clog2(MaxItems);
  localparam int BoundW     = PrefW + 1;
  localparam int PairW      = 20;
  localparam int AddrW      = 3;
  localparam int DataW      = 32;

  localparam logic RegLower = 1'b0;
  localparam logic RegUpper = 1'b1;

  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic                     drop;
    logic [CntW-1:0]          n;
    logic signed [PrefW-1:0]  p;
    logic signed [BoundW-1:0] lo;
    logic signed [BoundW-1:0] hi;
    logic [CntW-1:0]          hits;
  } tok_t;

endpackage

// ===== hw/rtl/rsp_front.sv =====
// entry stage: restart, fill tracking, running prefix and match window per word
`timescale 1ns / 1ps

module rsp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          in_valid_i,
  input  logic signed [rsp_pkg::ValW-1:0] value_i,
  input  logic                          first_i,
  input  logic signed [rsp_pkg::ValW-1:0] lower_i,
  input  logic signed [rsp_pkg::ValW-1:0] upper_i,
  output rsp_pkg::tok_t                 tok_o
);

  logic [rsp_pkg::CntW-1:0]           total_q, total_d;
  logic signed [rsp_pkg::PrefW-1:0]   prefix_q, prefix_d;
  logic [rsp_pkg::CntW-1:0]           base_total;
  logic signed [rsp_pkg::PrefW-1:0]   base_prefix;
  logic signed [rsp_pkg::BoundW-1:0]  p_full;
  logic signed [rsp_pkg::BoundW-1:0]  lo_full;
  logic signed [rsp_pkg::BoundW-1:0]  hi_full;
  logic                               drop;
  logic                               take;
  logic                               valid_q;
  rsp_pkg::tok_t                      tok_q;

  assign take        = in_valid_i && adv_i;
  assign base_total  = first_i ? rsp_pkg::CntW'(1) : total_q;
  assign base_prefix = first_i ? '0 : prefix_q;
  assign drop        = (base_total >= rsp_pkg::CntW'(rsp_pkg::StoreDepth));

  assign p_full  = rsp_pkg::BoundW'(base_prefix) + rsp_pkg::BoundW'(value_i);
  assign lo_full = rsp_pkg::BoundW'(base_prefix) + rsp_pkg::BoundW'(value_i)
                 - rsp_pkg::BoundW'(upper_i);
  assign hi_full = rsp_pkg::BoundW'(base_prefix) + rsp_pkg::BoundW'(value_i)
                 - rsp_pkg::BoundW'(lower_i);

  always_comb begin
    total_d  = total_q;
    prefix_d = prefix_q;
    if (take && !drop) begin
      total_d  = base_total + rsp_pkg::CntW'(1);
      prefix_d = p_full[rsp_pkg::PrefW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= rsp_pkg::CntW'(1);
      prefix_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      total_q  <= total_d;
      prefix_q <= prefix_d;
      if (adv_i) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tok_q.valid <= 1'b1;
      tok_q.first <= first_i;
      tok_q.drop  <= drop;
      tok_q.n     <= base_total;
      tok_q.p     <= p_full[rsp_pkg::PrefW-1:0];
      tok_q.lo    <= lo_full;
      tok_q.hi    <= hi_full;
      tok_q.hits  <= '0;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

// ===== hw/rtl/rsp_cell.sv =====
// one stored prefix: compares the passing word against it and stores a new prefix
`timescale 1ns / 1ps

module rsp_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic [rsp_pkg::CntW-1:0] idx_i,
  input  rsp_pkg::tok_t            tok_i,
  output rsp_pkg::tok_t            tok_o
);

  logic signed [rsp_pkg::PrefW-1:0]  q_q;
  logic signed [rsp_pkg::BoundW-1:0] q_ext;
  logic                              live;
  logic                              hit;
  logic                              wr;
  logic                              valid_q;
  rsp_pkg::tok_t                     tok_q, tok_d;

  assign q_ext = rsp_pkg::BoundW'(q_q);
  assign live  = tok_i.valid && !tok_i.drop;
  assign hit   = live && (idx_i < tok_i.n)
              && ($signed(q_ext) >= $signed(tok_i.lo))
              && ($signed(q_ext) <= $signed(tok_i.hi));
  assign wr    = adv_i && live && (idx_i == tok_i.n);

  always_ff @(posedge clk_i) begin
    if (wr) begin
      q_q <= tok_i.p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= tok_i.valid;
    end
  end

  always_comb begin
    tok_d      = tok_i;
    tok_d.hits = tok_i.hits + rsp_pkg::CntW'(hit);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

// ===== hw/rtl/range_sum_pair_counter.sv =====
// top level: config registers, entry stage, chain of prefix cells and result register
//
//   channel  direction  handshake               payload
//   in       to block   in_valid_i/in_stall_o   value_i, first_i
//   out      from block out_valid_o/out_stall_i pair_count_o, overflow_o
//   cfg      to block   psel/penable/pready     paddr, pwdata, prdata
//
// one word enters per cycle while in_stall_o is low; its result reaches the result register
// after the word walks from the entry stage down the row of MaxItems prefix cells
// the whole row freezes while a result waits under out_stall_i
// reset empties the row and leaves only the zero prefix stored
`timescale 1ns / 1ps

module range_sum_pair_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [rsp_pkg::ValW-1:0]   value_i,
  input  logic                              first_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rsp_pkg::PairW-1:0]         pair_count_o,
  output logic                              overflow_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rsp_pkg::AddrW-1:0]         paddr,
  input  logic [rsp_pkg::DataW-1:0]         pwdata,
  output logic [rsp_pkg::DataW-1:0]         prdata,
  output logic                              pready
);

  logic signed [rsp_pkg::ValW-1:0] lower_q;
  logic signed [rsp_pkg::ValW-1:0] upper_q;
  logic                            adv;
  logic                            out_valid_q;
  logic [rsp_pkg::PairW-1:0]       pair_total_q, pair_total_d;
  logic [rsp_pkg::PairW-1:0]       pair_count_q;
  logic                            overflow_q;
  logic                            hit0;
  logic [rsp_pkg::CntW-1:0]        item_hits;
  rsp_pkg::tok_t                   tok [rsp_pkg::MaxItems+1];
  rsp_pkg::tok_t                   tok_end;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        rsp_pkg::RegLower: lower_q <= pwdata;
        rsp_pkg::RegUpper: upper_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rsp_pkg::RegLower: prdata = lower_q;
      rsp_pkg::RegUpper: prdata = upper_q;
      default:           prdata = '0;
    endcase
  end

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  rsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .value_i    (value_i),
    .first_i    (first_i),
    .lower_i    (lower_q),
    .upper_i    (upper_q),
    .tok_o      (tok[0])
  );

  for (genvar k = 1; k <= rsp_pkg::MaxItems; k++) begin : g_cell
    rsp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .idx_i  (rsp_pkg::CntW'(k)),
      .tok_i  (tok[k-1]),
      .tok_o  (tok[k])
    );
  end

  assign tok_end = tok[rsp_pkg::MaxItems];

  // zero prefix sits outside the row
  assign hit0 = ($signed(tok_end.lo) <= 0) && ($signed(tok_end.hi) >= 0);
  assign item_hits = tok_end.drop ? '0 : (tok_end.hits + rsp_pkg::CntW'(hit0));
  assign pair_total_d = (tok_end.first ? '0 : pair_total_q)
                      + rsp_pkg::PairW'(item_hits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pair_total_q <= '0;
    end else if (adv) begin
      out_valid_q <= tok_end.valid;
      if (tok_end.valid) begin
        pair_total_q <= pair_total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tok_end.valid) begin
      pair_count_q <= pair_total_d;
      overflow_q   <= tok_end.drop;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pair_count_o = pair_count_q;
  assign overflow_o   = overflow_q;

  a_entry_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[0].valid |-> (tok[0].n >= rsp_pkg::CntW'(1))
                  && (tok[0].n <= rsp_pkg::CntW'(rsp_pkg::StoreDepth)))
    else $error("entry fill count out of range");

  a_hits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end.valid |-> (tok_end.hits < tok_end.n))
    else $error("more matches than stored prefixes");

  a_drop_no_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_end.valid && tok_end.drop) |-> (tok_end.hits == '0))
    else $error("dropped word collected matches");

  a_drop_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && tok_end.valid && tok_end.drop) |=> (pair_total_q == $past(pair_total_q)))
    else $error("dropped word changed the total");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> (tok_end == $past(tok_end)))
    else $error("cell row moved while result stalled");

endmodule
